// File: rtl/core/sled_pkg.sv
// Shared types, constants and command table for the serial line LED decoder.
// Used by sled_front, sled_queue, sled_back, sled_checker and the top level; depends on nothing.
`default_nettype none

package sled_pkg;

  localparam int LINE_CAPACITY = 64;
  localparam int LEN_W         = $clog2(LINE_CAPACITY);
  localparam int CMD_COUNT     = 16;
  localparam int CMD_MAX_LEN   = 8;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_NUL  = 8'h00;
  localparam logic [7:0] CHAR_UP_A = 8'h41;
  localparam logic [7:0] CHAR_UP_Z = 8'h5A;
  localparam logic [7:0] CASE_GAP  = 8'd32;

  localparam logic [4:0] CODE_ALL_ON   = 5'd8;
  localparam logic [4:0] CODE_ALL_OFF  = 5'd9;
  localparam logic [4:0] CODE_HELP     = 5'd10;
  localparam logic [4:0] CODE_TOGGLE0  = 5'd11;
  localparam logic [4:0] CODE_TOGGLE3  = 5'd14;
  localparam logic [4:0] CODE_GET_TIME = 5'd15;
  localparam logic [4:0] CODE_UNKNOWN  = 5'd16;

  localparam logic [3:0] LEDS_DARK = 4'hF;
  localparam logic [3:0] LEDS_LIT  = 4'h0;

  typedef struct packed {
    logic [4:0]  code;
    logic [31:0] total;
  } sled_entry_t;

  // Command text, first character in the most significant stored byte.
  function automatic logic [63:0] cmd_str(input logic [3:0] k);
    logic [63:0] s;
    unique case (k)
      4'd0:  s = 64'("led0 on");
      4'd1:  s = 64'("led0 off");
      4'd2:  s = 64'("led1 on");
      4'd3:  s = 64'("led1 off");
      4'd4:  s = 64'("led2 on");
      4'd5:  s = 64'("led2 off");
      4'd6:  s = 64'("led3 on");
      4'd7:  s = 64'("led3 off");
      4'd8:  s = 64'("all on");
      4'd9:  s = 64'("all off");
      4'd10: s = 64'("help");
      4'd11: s = 64'("0c");
      4'd12: s = 64'("1c");
      4'd13: s = 64'("2c");
      4'd14: s = 64'("3c");
      default: s = 64'("get time");
    endcase
    return s;
  endfunction

  function automatic logic [3:0] cmd_len(input logic [3:0] k);
    logic [3:0] l;
    unique case (k)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd9: l = 4'd7;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd15: l = 4'd8;
      4'd8:  l = 4'd6;
      4'd10: l = 4'd4;
      default: l = 4'd2;
    endcase
    return l;
  endfunction

  // Character at position pos of command k; only meaningful for pos < length.
  function automatic logic [7:0] cmd_char(input logic [3:0] k, input logic [2:0] pos);
    logic [63:0] s;
    logic [3:0]  idx;
    s   = cmd_str(k);
    idx = cmd_len(k) - 4'd1 - {1'b0, pos};
    return s[idx[2:0]*8 +: 8];
  endfunction

  // Commands whose length equals len.
  function automatic logic [CMD_COUNT-1:0] length_mask(input logic [LEN_W-1:0] len);
    logic [CMD_COUNT-1:0] m;
    m = '0;
    for (int k = 0; k < CMD_COUNT; k++) begin
      if (LEN_W'(cmd_len(4'(k))) == len) m[k] = 1'b1;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/sled_front.sv
// Front end: accepts bytes, counts them, tracks the line and the per-command match vector.
// Pushes one decoded entry per completed line; depends on sled_pkg.
`default_nettype none

module sled_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  byte_take,
  input  wire logic [7:0]            byte_in,
  output logic                       push,
  output sled_pkg::sled_entry_t      push_entry
);

  logic [sled_pkg::LEN_W-1:0]     len_r, len_nxt;
  logic [sled_pkg::CMD_COUNT-1:0] alive_r, alive_nxt;
  logic                           frozen_r, frozen_nxt;
  logic [31:0]                    total_r, total_nxt;

  logic                           is_eol;
  logic [7:0]                     folded;
  logic [sled_pkg::CMD_COUNT-1:0] kill;
  logic [sled_pkg::CMD_COUNT-1:0] final_alive;
  logic [4:0]                     code;

  assign is_eol = (byte_in == sled_pkg::CHAR_CR) || (byte_in == sled_pkg::CHAR_LF);
  assign folded = ((byte_in >= sled_pkg::CHAR_UP_A) && (byte_in <= sled_pkg::CHAR_UP_Z)) ?
                  byte_in + sled_pkg::CASE_GAP : byte_in;

  always_comb begin
    for (int k = 0; k < sled_pkg::CMD_COUNT; k++) begin
      kill[k] = (len_r >= sled_pkg::LEN_W'(sled_pkg::cmd_len(4'(k)))) ||
                (sled_pkg::cmd_char(4'(k), len_r[2:0]) != folded);
    end
  end

  // A zero byte already froze the vector, so the length check was applied then.
  assign final_alive = frozen_r ? alive_r : (alive_r & sled_pkg::length_mask(len_r));

  always_comb begin
    code = sled_pkg::CODE_UNKNOWN;
    for (int k = sled_pkg::CMD_COUNT - 1; k >= 0; k--) begin
      if (final_alive[k]) code = 5'(k);
    end
  end

  assign total_nxt        = byte_take ? total_r + 32'd1 : total_r;
  assign push             = byte_take && is_eol && (len_r != '0);
  assign push_entry.code  = code;
  assign push_entry.total = total_nxt;

  always_comb begin
    len_nxt    = len_r;
    alive_nxt  = alive_r;
    frozen_nxt = frozen_r;
    if (byte_take) begin
      if (is_eol) begin
        if (len_r != '0) begin
          len_nxt    = '0;
          alive_nxt  = '1;
          frozen_nxt = 1'b0;
        end
      end else if (len_r < sled_pkg::LEN_W'(sled_pkg::LINE_CAPACITY - 1)) begin
        if (!frozen_r) begin
          if (byte_in == sled_pkg::CHAR_NUL) begin
            alive_nxt  = alive_r & sled_pkg::length_mask(len_r);
            frozen_nxt = 1'b1;
          end else begin
            alive_nxt  = alive_r & ~kill;
          end
        end
        len_nxt = len_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      alive_r  <= '1;
      frozen_r <= 1'b0;
      total_r  <= '0;
    end else begin
      len_r    <= len_nxt;
      alive_r  <= alive_nxt;
      frozen_r <= frozen_nxt;
      total_r  <= total_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sled_queue.sv
// Short queue of decoded line entries between front and back end.
// Depends on sled_pkg for the entry type and depth.
`default_nettype none

module sled_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  sled_pkg::sled_entry_t      push_entry,
  input  wire logic                  pop,
  output sled_pkg::sled_entry_t      head,
  output logic                       not_empty,
  output logic                       full
);

  sled_pkg::sled_entry_t             mem [sled_pkg::QUEUE_DEPTH];
  logic [sled_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [sled_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [sled_pkg::QCNT_W-1:0]       count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == sled_pkg::QCNT_W'(sled_pkg::QUEUE_DEPTH));
  assign head      = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + sled_pkg::QCNT_W'(push) - sled_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sled_back.sv
// Back end: applies each decoded command to the LED pins and holds the result register.
// Depends on sled_pkg.
`default_nettype none

module sled_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  avail,
  input  sled_pkg::sled_entry_t      entry,
  output logic                       pop,
  input  wire logic                  res_ready,
  output logic                       res_valid,
  output logic [4:0]                 res_code,
  output logic [3:0]                 res_leds,
  output logic [31:0]                res_total
);

  logic [3:0]  leds_r, leds_nxt;
  logic        valid_r, valid_nxt;
  logic [4:0]  code_r;
  logic [31:0] total_r;
  logic [1:0]  sel;
  logic [1:0]  tgl;

  assign pop = avail && (!valid_r || res_ready);
  assign sel = entry.code[2:1];
  assign tgl = 2'(entry.code - sled_pkg::CODE_TOGGLE0);

  always_comb begin
    leds_nxt = leds_r;
    if (entry.code < sled_pkg::CODE_ALL_ON) begin
      leds_nxt[sel] = entry.code[0];
    end else if (entry.code == sled_pkg::CODE_ALL_ON) begin
      leds_nxt = sled_pkg::LEDS_LIT;
    end else if (entry.code == sled_pkg::CODE_ALL_OFF) begin
      leds_nxt = sled_pkg::LEDS_DARK;
    end else if ((entry.code >= sled_pkg::CODE_TOGGLE0) &&
                 (entry.code <= sled_pkg::CODE_TOGGLE3)) begin
      leds_nxt[tgl] = ~leds_r[tgl];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (pop) valid_nxt = 1'b1;
    else if (res_ready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leds_r  <= sled_pkg::LEDS_DARK;
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (pop) leds_r <= leds_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      code_r  <= entry.code;
      total_r <= entry.total;
    end
  end

  assign res_valid = valid_r;
  assign res_code  = code_r;
  assign res_leds  = leds_r;
  assign res_total = total_r;

endmodule

`default_nettype wire

// File: rtl/core/serial_line_led_command_decoder_top.sv
// Serial line LED command decoder: top level tying front end, queue and back end together.
// Depends on sled_pkg, sled_front, sled_queue and sled_back.
//
// Usage: received serial bytes enter on the in_ stream, one byte per transfer.
// Every byte is counted. Bytes build a line of up to 63 characters (extra ones
// are dropped); CR or LF ends a non-empty line, which is matched without regard
// to letter case against sixteen fixed commands. Each completed line produces
// one transfer on the out_ stream with the response code, the LED pin levels
// after the command (0 = lit) and the running byte count. Other bytes produce
// nothing.
// Throughput: one byte per clock cycle while in_tready is high. A line's result
// is held first in the queue, which takes the entry at the edge that accepts its
// CR or LF, then in the back end's output register once that is empty or read.
// A two-entry queue separates the front end from the back end; when the
// receiver stalls, results wait in the output register and the queue, and
// in_tready drops only once the queue is full.
// Reset clears the byte count, the line, the queue and the output valid flag,
// and turns all LEDs dark (pins high).
`default_nettype none

module serial_line_led_command_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata   // [4:0] response_code, [8:5] led_levels,
                                       // [40:9] bytes_received, [47:41] zero
);

  logic                  byte_take;
  logic                  push;
  logic                  pop;
  logic                  q_not_empty;
  logic                  q_full;
  sled_pkg::sled_entry_t push_entry;
  sled_pkg::sled_entry_t head;
  logic [4:0]            res_code;
  logic [3:0]            res_leds;
  logic [31:0]           res_total;

  assign in_tready = !q_full;
  assign byte_take = in_tvalid && in_tready;

  sled_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_take  (byte_take),
    .byte_in    (in_tdata),
    .push       (push),
    .push_entry (push_entry)
  );

  sled_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .not_empty  (q_not_empty),
    .full       (q_full)
  );

  sled_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .avail      (q_not_empty),
    .entry      (head),
    .pop        (pop),
    .res_ready  (out_tready),
    .res_valid  (out_tvalid),
    .res_code   (res_code),
    .res_leds   (res_leds),
    .res_total  (res_total)
  );

  assign out_tdata = {7'd0, res_total, res_leds, res_code};

endmodule

`default_nettype wire

// File: rtl/core/sled_checker.sv
// Port-level checks for the serial line LED command decoder.
// Depends on sled_pkg; bound to serial_line_led_command_decoder_top below.
`default_nettype none

module sled_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata
);

  logic [4:0] code;
  logic [3:0] leds;

  assign code = out_tdata[4:0];
  assign leds = out_tdata[8:5];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> code <= sled_pkg::CODE_UNKNOWN)
    else $error("response code out of range");

  a_all_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && code == sled_pkg::CODE_ALL_ON |-> leds == sled_pkg::LEDS_LIT)
    else $error("all on left an LED dark");

  a_all_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && code == sled_pkg::CODE_ALL_OFF |-> leds == sled_pkg::LEDS_DARK)
    else $error("all off left an LED lit");

  // A line needs at least one stored byte and an end byte; with no byte accepted
  // and no result valid over the sampled past, no result may appear.
  a_no_result_from_nothing: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(in_tvalid && in_tready) && !$past(in_tvalid && in_tready, 2) &&
    !$past(out_tvalid) && !$past(out_tvalid, 2) |-> !out_tvalid)
    else $error("result without a completed line");

endmodule

bind serial_line_led_command_decoder_top sled_checker u_sled_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
